// ===== rtl/upbd_pkg.sv =====
// package: types and constants of the udp port bind and demux table
package upbd_pkg;

	localparam logic [1:0] OP_BIND    = 2'd0;
	localparam logic [1:0] OP_CONNECT = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;
	localparam logic [1:0] OP_LOOKUP  = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BOUND     = 3'd1;
	localparam logic [2:0] ST_IN_USE    = 3'd2;
	localparam logic [2:0] ST_NO_MATCH  = 3'd3;
	localparam logic [2:0] ST_NO_EPHEM  = 3'd4;

	localparam logic [0:0] REG_EPH_LOW  = 1'b0;
	localparam logic [0:0] REG_EPH_HIGH = 1'b1;

	localparam logic [15:0] EPH_LOW_RESET  = 16'd32768;
	localparam logic [15:0] EPH_HIGH_RESET = 16'd60999;

	// one packed entry of the table memory
	typedef struct packed {
		logic [31:0] local_ip;
		logic [15:0] local_port;
		logic [31:0] peer_ip;
		logic [15:0] peer_port;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// commands from controller to datapath
	typedef struct packed {
		logic        load;      // capture the input item
		logic        scan_clr;  // restart a scan at entry 0
		logic        scan_step; // advance scan address
		logic        lk_eval;   // evaluate returned entry for lookup
		logic        pc_eval;   // evaluate returned entry for port check
		logic        cand_init; // set candidate from cursor (ephemeral)
		logic        cand_user; // set candidate from item port
		logic        cand_next; // advance cursor, candidate becomes cursor
		logic        do_write;  // write the entry / flags
		logic        do_conn;   // write peer fields and connected
		logic        do_rel;    // clear flags
		logic        cur_save;  // store the advanced cursor
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic        scan_last;  // scan address at last slot
		logic        taken;      // candidate seen as taken
		logic        found;      // exact connected lookup match
		logic        range_bad;  // ephemeral range empty
		logic        tries_done; // whole range tried
		logic        slot_ok;    // slot within table
		logic        slot_bound;
		logic        port_zero;  // item port is zero, pick ephemeral
	} stat_t;

endpackage

// ===== rtl/upbd_if.sv =====
// interfaces: valid/ready item channels and configuration write channel
interface upbd_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [5:0]  slot;
	logic [31:0] addr_ip;
	logic [15:0] addr_port;
	logic [31:0] peer_ip;
	logic [15:0] peer_port;
	modport source (output valid, op, slot, addr_ip, addr_port, peer_ip, peer_port,
		input ready);
	modport sink (input valid, op, slot, addr_ip, addr_port, peer_ip, peer_port,
		output ready);
endinterface

interface upbd_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [5:0]  hit_slot;
	logic [15:0] bound_port;
	modport source (output valid, status, hit_slot, bound_port, input ready);
	modport sink (input valid, status, hit_slot, bound_port, output ready);
endinterface

interface upbd_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/upbd_ram.sv =====
// generic single-port-write, single-read ram with registered read
module upbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/upbd_datapath.sv =====
// datapath: item registers, entry memory, flags, scan counter, cursor and compares
module upbd_datapath
	import upbd_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic [1:0]  in_op,
	input  logic [5:0]  in_slot,
	input  logic [31:0] in_addr_ip,
	input  logic [15:0] in_addr_port,
	input  logic [31:0] in_peer_ip,
	input  logic [15:0] in_peer_port,
	input  logic [15:0] eph_low,
	input  logic [15:0] eph_high,
	output logic [5:0]  hit_slot,
	output logic [15:0] cand_port,
	output logic        have_best
);
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int HALF_W = ENTRY_W / 2;

	logic [1:0]  op_q;
	logic [5:0]  slot_q;
	logic [31:0] aip_q, pip_q;
	logic [15:0] aport_q, pport_q;
	logic [SLOTS-1:0] bound_q, conn_q;
	logic [AW-1:0] scan_q, eval_q;
	logic [15:0] cursor_q, cand_q;
	logic [16:0] tries_q;
	logic        taken_q, found_q, best_q;
	logic [5:0]  best_idx_q;
	logic        eval_val_q;
	entry_t      rd_entry;
	logic [HALF_W-1:0] local_wr, peer_wr, local_rd, peer_rd;
	logic [AW-1:0] slot_a, rd_addr;

	assign slot_a = AW'(slot_q);

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_op; slot_q <= in_slot;
			aip_q <= in_addr_ip; aport_q <= in_addr_port;
			pip_q <= in_peer_ip; pport_q <= in_peer_port;
		end
	end

	// entry memories: local half and peer half, read at scan address or target slot
	assign local_wr = {((op_q == OP_BIND) ? aip_q : 32'd0), cand_q};
	assign peer_wr = {aip_q, aport_q};
	assign rd_addr = cmd.scan_clr ? slot_a : scan_q;

	upbd_ram #(.WIDTH(HALF_W), .DEPTH(SLOTS)) u_ram_local (
		.clk(clk), .we(cmd.do_write), .waddr(slot_a), .wdata(local_wr),
		.raddr(rd_addr), .rdata(local_rd)
	);

	upbd_ram #(.WIDTH(HALF_W), .DEPTH(SLOTS)) u_ram_peer (
		.clk(clk), .we(cmd.do_conn), .waddr(slot_a), .wdata(peer_wr),
		.raddr(rd_addr), .rdata(peer_rd)
	);

	assign rd_entry = {local_rd, peer_rd};

	// scan counter; the eval index is registered from the scan address, so it lines up with the registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0; eval_q <= '0; eval_val_q <= 1'b0;
		end else begin
			eval_val_q <= cmd.scan_step;
			eval_q <= scan_q;
			if (cmd.scan_clr) scan_q <= '0;
			else if (cmd.scan_step) scan_q <= scan_q + AW'(1);
		end
	end

	// flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q <= '0; conn_q <= '0;
		end else begin
			if (cmd.do_write) bound_q[slot_a] <= 1'b1;
			if (cmd.do_conn) conn_q[slot_a] <= 1'b1;
			if (cmd.do_rel) begin
				bound_q[slot_a] <= 1'b0; conn_q[slot_a] <= 1'b0;
			end
		end
	end

	// per-entry compare
	logic e_bnd, e_con, lk_cand, lk_exact, pc_hit;
	assign e_bnd = bound_q[eval_q];
	assign e_con = conn_q[eval_q];
	assign lk_cand = e_bnd && rd_entry.local_port == aport_q &&
		(rd_entry.local_ip == 32'd0 || rd_entry.local_ip == aip_q);
	assign lk_exact = lk_cand && e_con && rd_entry.peer_ip == pip_q &&
		rd_entry.peer_port == pport_q;
	assign pc_hit = e_bnd && rd_entry.local_port == cand_q;

	// scan accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= 1'b0; found_q <= 1'b0; best_q <= 1'b0; best_idx_q <= '0;
		end else if (cmd.scan_clr) begin
			taken_q <= 1'b0; found_q <= 1'b0; best_q <= 1'b0; best_idx_q <= '0;
		end else if (eval_val_q) begin
			if (cmd.pc_eval && pc_hit) taken_q <= 1'b1;
			if (cmd.lk_eval && !found_q) begin
				if (lk_exact) begin
					found_q <= 1'b1; best_idx_q <= 6'(eval_q);
				end else if (lk_cand && !e_con && !best_q) begin
					best_q <= 1'b1; best_idx_q <= 6'(eval_q);
				end
			end
		end
	end

	// ephemeral cursor and candidate
	logic [15:0] cur_eff, cur_adv;
	assign cur_eff = (cursor_q < eph_low || cursor_q > eph_high) ? eph_low : cursor_q;
	assign cur_adv = (cand_q >= eph_high) ? eph_low : cand_q + 16'd1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= EPH_LOW_RESET; cand_q <= '0; tries_q <= '0;
		end else begin
			if (cmd.cand_user) cand_q <= aport_q;
			if (cmd.cand_init) begin
				cand_q <= cur_eff; cursor_q <= cur_eff; tries_q <= 17'd1;
			end
			if (cmd.cand_next) begin
				cand_q <= cur_adv; cursor_q <= cur_adv; tries_q <= tries_q + 17'd1;
			end
			if (cmd.cur_save) cursor_q <= cur_adv;
		end
	end

	logic [16:0] span;
	assign span = {1'b0, eph_high} - {1'b0, eph_low} + 17'd1;

	assign stat.scan_last  = (scan_q == AW'(SLOTS - 1));
	assign stat.taken      = taken_q || (cand_q == 16'd0);
	assign stat.found      = found_q;
	assign stat.range_bad  = eph_high < eph_low;
	assign stat.tries_done = tries_q >= span;
	assign stat.slot_ok    = 32'(slot_q) < 32'(SLOTS);
	assign stat.slot_bound = bound_q[slot_a];
	assign stat.port_zero  = (aport_q == 16'd0);
	assign hit_slot  = best_idx_q;
	assign cand_port = cand_q;
	assign have_best = found_q || best_q;
endmodule

// ===== rtl/upbd_ctrl.sv =====
// controller: sequences bind, connect, release and lookup over the slot scan
module upbd_ctrl
	import upbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  in_op,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  out_status,
	output logic        out_sel_hit,
	output logic        out_sel_port,
	output cmd_t        cmd,
	input  stat_t       stat,
	input  logic        have_best
);
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_DEC   = 7'b0000010,
		S_SCAN  = 7'b0000100,
		S_DRAIN = 7'b0001000,
		S_CHECK = 7'b0010000,
		S_NEXT  = 7'b0100000,
		S_RESP  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic [1:0] op_q;
	logic       eph_q, lk_q;
	logic [2:0] st_q, st_d;
	logic       selp_q, selp_d, eph_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_RESP);
	assign out_status = st_q;
	assign out_sel_hit = lk_q && st_q == ST_OK;
	assign out_sel_port = selp_q;

	// next state and commands
	always_comb begin
		state_d = state_q; cmd = '0; st_d = st_q; selp_d = selp_q; eph_d = eph_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1; state_d = S_DEC; st_d = ST_OK; selp_d = 1'b0;
				end
			end
			S_DEC: begin
				cmd.scan_clr = 1'b1;
				if (op_q == OP_LOOKUP) state_d = S_SCAN;
				else if (!stat.slot_ok) state_d = S_RESP;
				else if (op_q == OP_RELEASE) begin
					cmd.do_rel = 1'b1; state_d = S_RESP;
				end else if (stat.slot_bound) begin
					if (op_q == OP_BIND) st_d = ST_BOUND;
					else cmd.do_conn = 1'b1;
					state_d = S_RESP;
				end else begin
					eph_d = (op_q == OP_CONNECT) || stat.port_zero;
					if (eph_d) begin
						if (stat.range_bad) begin
							st_d = ST_NO_EPHEM; state_d = S_RESP;
						end else begin
							cmd.cand_init = 1'b1; state_d = S_SCAN;
						end
					end else begin
						cmd.cand_user = 1'b1; state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				cmd.lk_eval = (op_q == OP_LOOKUP); cmd.pc_eval = (op_q != OP_LOOKUP);
				if (stat.scan_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				cmd.lk_eval = (op_q == OP_LOOKUP); cmd.pc_eval = (op_q != OP_LOOKUP);
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (op_q == OP_LOOKUP) begin
					if (!have_best) st_d = ST_NO_MATCH;
					state_d = S_RESP;
				end else if (!stat.taken) begin
					cmd.do_write = 1'b1; cmd.do_conn = (op_q == OP_CONNECT);
					if (eph_q) cmd.cur_save = 1'b1;
					selp_d = 1'b1; state_d = S_RESP;
				end else if (!eph_q) begin
					st_d = ST_IN_USE; state_d = S_RESP;
				end else if (stat.tries_done) begin
					cmd.cur_save = 1'b1; st_d = ST_NO_EPHEM; state_d = S_RESP;
				end else begin
					state_d = S_NEXT;
				end
			end
			S_NEXT: begin
				cmd.cand_next = 1'b1; cmd.scan_clr = 1'b1; state_d = S_SCAN;
			end
			S_RESP: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; op_q <= OP_BIND; eph_q <= 1'b0; lk_q <= 1'b0;
			st_q <= ST_OK; selp_q <= 1'b0;
		end else begin
			state_q <= state_d; st_q <= st_d; selp_q <= selp_d; eph_q <= eph_d;
			if (cmd.load) begin
				op_q <= in_op; lk_q <= 1'b0;
			end
			if (state_q == S_DEC) lk_q <= (op_q == OP_LOOKUP);
		end
	end

`ifndef ASSERT_OFF
	a_one_state: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_resp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(st_q))
		else $error("response dropped while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !cmd.load)
		else $error("item loaded while busy");
`endif
endmodule

// ===== rtl/udp_port_bind_and_demux_table_core.sv =====
// top level: udp port bind and demux table
// Usage:
//   req carries one item (op, slot, addr_ip, addr_port, peer_ip, peer_port);
//   it is taken when valid and ready are high, one item at a time.
//   rsp returns exactly one item (status, hit_slot, bound_port) per request.
//   cfg writes ephemeral_low (index 0) or ephemeral_high (index 1); it is
//   always ready; the new value is also seen by an item in progress.
// Sequence, from the accepted item to response valid:
//   release, an out-of-range slot, a bind to a bound slot, a connect to a
//   bound slot or an empty ephemeral range: decode, then response.
//   lookup or bind of a fixed port: decode, the one-entry-a-cycle scan of
//   the entry memory's read port over all SLOTS, drain, check, response.
//   ephemeral bind/connect: scan, drain, check for each candidate tried.
// One item at a time: the next item is taken only in the idle state after
//   the response handshake.
// Reset: all entries unbound and unconnected, cursor and control registers
//   to defaults; no clearing pass, entry contents are used only after a write.
// Stall: the response holds until rsp.ready; no new item is taken meanwhile.
module udp_port_bind_and_demux_table_core
	import upbd_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input  logic clk,
	input  logic arst_n,
	upbd_req_if.sink   req,
	upbd_rsp_if.source rsp,
	upbd_cfg_if.sink   cfg
);
	cmd_t  cmd;
	stat_t stat;
	logic [15:0] eph_low_q, eph_high_q, cand_port;
	logic [5:0]  hit_slot;
	logic        have_best, sel_hit, sel_port;

	// configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eph_low_q <= EPH_LOW_RESET; eph_high_q <= EPH_HIGH_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_EPH_LOW:  eph_low_q <= cfg.data;
				REG_EPH_HIGH: eph_high_q <= cfg.data;
				default: ;
			endcase
		end
	end

	upbd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready), .in_op(req.op),
		.out_valid(rsp.valid), .out_ready(rsp.ready), .out_status(rsp.status),
		.out_sel_hit(sel_hit), .out_sel_port(sel_port),
		.cmd(cmd), .stat(stat), .have_best(have_best)
	);

	upbd_datapath #(.SLOTS(SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_op(req.op), .in_slot(req.slot), .in_addr_ip(req.addr_ip),
		.in_addr_port(req.addr_port), .in_peer_ip(req.peer_ip),
		.in_peer_port(req.peer_port), .eph_low(eph_low_q), .eph_high(eph_high_q),
		.hit_slot(hit_slot), .cand_port(cand_port), .have_best(have_best)
	);

	assign rsp.hit_slot   = sel_hit ? hit_slot : 6'd0;
	assign rsp.bound_port = sel_port ? cand_port : 16'd0;
endmodule

// ===== tb/sv/tb_udp_port_bind_and_demux_table_core.sv =====
// testbench: udp port bind and demux table core against a behavioral predictor
`timescale 1ns / 100ps

module tb_udp_port_bind_and_demux_table_core;
	import upbd_pkg::*;

	localparam int NSLOT = 64;
	localparam longint CYCLE_LIMIT = 30000000;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  hit_slot;
		logic [15:0] bound_port;
	} answer_t;

	logic clk;
	logic arst_n;

	upbd_req_if req ();
	upbd_rsp_if rsp ();
	upbd_cfg_if cfg ();

	udp_port_bind_and_demux_table_core #(.SLOTS(NSLOT)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source),
		.cfg(cfg.sink)
	);

	// shadow copy of the socket table
	logic        sh_bound     [NSLOT];
	logic [31:0] sh_local_ip  [NSLOT];
	logic [15:0] sh_local_port[NSLOT];
	logic        sh_conn      [NSLOT];
	logic [31:0] sh_peer_ip   [NSLOT];
	logic [15:0] sh_peer_port [NSLOT];
	logic [15:0] sh_cursor;
	logic [15:0] sh_eph_low;
	logic [15:0] sh_eph_high;

	answer_t answers_due[$];
	int      errors;
	longint  cycles;
	bit      no_idle;
	bit      hold_request;

	// clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("udp_port_bind_and_demux_table_core: mismatch");
			$finish;
		end
	end

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		errors++;
		$display("error at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
	endtask

	function automatic bit port_in_use(input logic [15:0] p);
		if (p == 16'd0)
			return 1'b1;
		for (int i = 0; i < NSLOT; i++)
			if (sh_bound[i] && sh_local_port[i] == p)
				return 1'b1;
		return 1'b0;
	endfunction

	// next free ephemeral port, 0 if none
	function automatic logic [15:0] next_ephemeral();
		logic [15:0] cand;
		int span;
		if (sh_eph_high < sh_eph_low)
			return 16'd0;
		if (sh_cursor < sh_eph_low || sh_cursor > sh_eph_high)
			sh_cursor = sh_eph_low;
		span = int'(sh_eph_high) - int'(sh_eph_low) + 1;
		for (int t = 0; t < span; t++) begin
			cand = sh_cursor;
			sh_cursor = (sh_cursor >= sh_eph_high) ? sh_eph_low : sh_cursor + 16'd1;
			if (!port_in_use(cand))
				return cand;
		end
		return 16'd0;
	endfunction

	// apply one request to the shadow table and give its answer
	function automatic answer_t table_step(input logic [1:0] op, input logic [5:0] slot,
		input logic [31:0] aip, input logic [15:0] aport,
		input logic [31:0] pip, input logic [15:0] pport);
		answer_t a;
		bit found, have_best;
		int best;
		logic [15:0] p;
		a = '0;
		a.status = ST_OK;
		if (op == OP_LOOKUP) begin
			found = 0;
			have_best = 0;
			best = 0;
			for (int i = 0; i < NSLOT && !found; i++) begin
				if (!sh_bound[i] || sh_local_port[i] != aport)
					continue;
				if (sh_local_ip[i] != 0 && sh_local_ip[i] != aip)
					continue;
				if (sh_conn[i]) begin
					if (sh_peer_ip[i] == pip && sh_peer_port[i] == pport) begin
						found = 1;
						best = i;
					end
					continue;
				end
				if (!have_best) begin
					have_best = 1;
					best = i;
				end
			end
			if (found || have_best)
				a.hit_slot = best[5:0];
			else
				a.status = ST_NO_MATCH;
		end else if (op == OP_BIND) begin
			if (sh_bound[slot]) begin
				a.status = ST_BOUND;
			end else begin
				p = aport;
				if (p == 0) begin
					p = next_ephemeral();
					if (p == 0)
						a.status = ST_NO_EPHEM;
				end else if (port_in_use(p)) begin
					a.status = ST_IN_USE;
				end
				if (a.status == ST_OK) begin
					sh_local_ip[slot] = aip;
					sh_local_port[slot] = p;
					sh_bound[slot] = 1'b1;
					a.bound_port = p;
				end
			end
		end else if (op == OP_CONNECT) begin
			if (!sh_bound[slot]) begin
				p = next_ephemeral();
				if (p == 0) begin
					a.status = ST_NO_EPHEM;
				end else begin
					sh_local_ip[slot] = '0;
					sh_local_port[slot] = p;
					sh_bound[slot] = 1'b1;
					a.bound_port = p;
				end
			end
			if (a.status == ST_OK) begin
				sh_peer_ip[slot] = aip;
				sh_peer_port[slot] = aport;
				sh_conn[slot] = 1'b1;
			end
		end else begin
			sh_bound[slot] = 1'b0;
			sh_conn[slot] = 1'b0;
		end
		return a;
	endfunction

	// offer one request and predict its answer on acceptance
	task automatic send_request(input logic [1:0] op, input logic [5:0] slot,
		input logic [31:0] aip, input logic [15:0] aport,
		input logic [31:0] pip, input logic [15:0] pport);
		int gap;
		gap = (!no_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.op <= op;
		req.slot <= slot;
		req.addr_ip <= aip;
		req.addr_port <= aport;
		req.peer_ip <= pip;
		req.peer_port <= pport;
		do @(posedge clk); while (!req.ready);
		answers_due.push_back(table_step(op, slot, aip, aport, pip, pport));
	endtask

	// write one register once the table is idle
	task automatic write_reg(input logic [0:0] idx, input logic [15:0] value);
		req.valid <= 1'b0;
		wait (answers_due.size() == 0);
		repeat (5) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == REG_EPH_LOW)
			sh_eph_low = value;
		else
			sh_eph_high = value;
	endtask

	// response check
	always @(posedge clk) begin
		answer_t want;
		if (rsp.valid && rsp.ready) begin
			if (answers_due.size() == 0) begin
				report("unexpected item status", 16'(rsp.status), 16'd0);
			end else begin
				want = answers_due.pop_front();
				if (rsp.status !== want.status)
					report("status", 16'(rsp.status), 16'(want.status));
				if (rsp.hit_slot !== want.hit_slot)
					report("hit_slot", 16'(rsp.hit_slot), 16'(want.hit_slot));
				if (rsp.bound_port !== want.bound_port)
					report("bound_port", rsp.bound_port, want.bound_port);
			end
		end
	end

	// response ready with random stall bursts and one long hold
	int stall_left = 0;
	int hold_left = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (hold_request) begin
				hold_left = 400;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 2);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	function automatic logic [31:0] pick_ip();
		case ($urandom_range(0, 4))
			0: return 32'h0;
			1: return 32'h0a000001;
			2: return 32'h0a000002;
			3: return 32'hffffffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_peer_ip();
		case ($urandom_range(0, 3))
			0: return 32'hc0a80001;
			1: return 32'hc0a80002;
			2: return 32'h0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_peer_port();
		case ($urandom_range(0, 3))
			0: return 16'd53;
			1: return 16'd5000;
			2: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	// random mix of requests, slots mostly low so ports collide
	task automatic run_random(input int count);
		logic [1:0] op;
		logic [5:0] slot, pick;
		logic [15:0] port;
		int sel;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			op = (sel < 30) ? OP_BIND : (sel < 48) ? OP_CONNECT :
				(sel < 65) ? OP_RELEASE : OP_LOOKUP;
			slot = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 15));
			case (op)
				OP_BIND: begin
					case ($urandom_range(0, 4))
						0, 1: port = 16'd0;
						2: port = 16'd1000 + 16'($urandom_range(0, 7));
						3: port = 16'hffff;
						default: port = 16'($urandom);
					endcase
					send_request(op, slot, pick_ip(), port, $urandom, 16'($urandom));
				end
				OP_CONNECT:
					send_request(op, slot, pick_peer_ip(), pick_peer_port(),
						$urandom, 16'($urandom));
				OP_RELEASE:
					send_request(op, slot, $urandom, 16'($urandom), $urandom, 16'($urandom));
				default: begin
					pick = 6'($urandom_range(0, 15));
					if ($urandom_range(0, 9) < 7 && sh_bound[pick])
						port = sh_local_port[pick];
					else
						port = 16'd1000 + 16'($urandom_range(0, 7));
					if ($urandom_range(0, 9) < 3 && sh_bound[pick] && sh_conn[pick])
						send_request(op, 6'($urandom), pick_ip(), port,
							sh_peer_ip[pick], sh_peer_port[pick]);
					else
						send_request(op, 6'($urandom), pick_ip(), port,
							pick_peer_ip(), pick_peer_port());
				end
			endcase
		end
	endtask

	task automatic release_all();
		for (int i = 0; i < NSLOT; i++)
			send_request(OP_RELEASE, 6'(i), '0, '0, '0, '0);
	endtask

	// directed: extremes, every operation and each status except ST_NO_EPHEM
	task automatic test_directed();
		send_request(OP_LOOKUP, 6'd0, 32'h0, 16'd0, 32'h0, 16'd0);
		send_request(OP_BIND, 6'd0, 32'h0, 16'd0, 32'h0, 16'd0);
		send_request(OP_BIND, 6'd63, 32'hffffffff, 16'hffff, 32'hffffffff, 16'hffff);
		send_request(OP_BIND, 6'd1, 32'h0a000001, 16'hffff, 32'h0, 16'd0);
		send_request(OP_BIND, 6'd0, 32'h0, 16'd7, 32'h0, 16'd0);
		send_request(OP_CONNECT, 6'd2, 32'hc0a80001, 16'd53, 32'h0, 16'd0);
		send_request(OP_CONNECT, 6'd63, 32'hffffffff, 16'hffff, 32'h0, 16'd0);
		send_request(OP_LOOKUP, 6'd0, 32'hffffffff, 16'hffff, 32'hffffffff, 16'hffff);
		send_request(OP_LOOKUP, 6'd0, 32'hffffffff, 16'hffff, 32'h1, 16'd1);
		send_request(OP_LOOKUP, 6'd0, 32'h12345678, 16'd32768, 32'h0, 16'd0);
		send_request(OP_LOOKUP, 6'd0, 32'h0, 16'd32769, 32'hc0a80001, 16'd53);
		send_request(OP_LOOKUP, 6'd0, 32'h0, 16'd32769, 32'hc0a80001, 16'd54);
		send_request(OP_BIND, 6'd3, 32'h0, 16'd32769, 32'h0, 16'd0);
		send_request(OP_RELEASE, 6'd2, 32'hffffffff, 16'hffff, 32'hffffffff, 16'hffff);
		send_request(OP_RELEASE, 6'd40, 32'h0, 16'd0, 32'h0, 16'd0);
		send_request(OP_BIND, 6'd3, 32'h0, 16'd32769, 32'h0, 16'd0);
		send_request(OP_LOOKUP, 6'd0, 32'h5, 16'd32769, 32'h0, 16'd0);
		release_all();
	endtask

	// narrow range runs out of ports
	task automatic test_exhaustion();
		write_reg(REG_EPH_LOW, 16'd100);
		write_reg(REG_EPH_HIGH, 16'd102);
		for (int i = 0; i < 5; i++)
			send_request((i % 2) ? OP_CONNECT : OP_BIND, 6'(10 + i), 32'h0, 16'd0,
				32'h0, 16'd0);
		release_all();
	endtask

	// range starting at port zero never hands out zero
	task automatic test_port_zero();
		write_reg(REG_EPH_LOW, 16'd0);
		write_reg(REG_EPH_HIGH, 16'd2);
		for (int i = 0; i < 4; i++)
			send_request(OP_BIND, 6'(i), 32'h0, 16'd0, 32'h0, 16'd0);
		run_random(150);
		release_all();
	endtask

	// high below low fails at once
	task automatic test_empty_range();
		write_reg(REG_EPH_LOW, 16'd500);
		write_reg(REG_EPH_HIGH, 16'd499);
		send_request(OP_BIND, 6'd5, 32'h0, 16'd0, 32'h0, 16'd0);
		send_request(OP_CONNECT, 6'd6, 32'h1, 16'd1, 32'h0, 16'd0);
		run_random(100);
	endtask

	// long response hold while requests keep coming
	task automatic test_backpressure();
		hold_request = 1;
		run_random(20);
	endtask

	initial begin
		errors = 0;
		no_idle = 0;
		hold_request = 0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.op = OP_BIND;
		req.slot = '0;
		req.addr_ip = '0;
		req.addr_port = '0;
		req.peer_ip = '0;
		req.peer_port = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_EPH_LOW;
		cfg.data = '0;
		rsp.ready = 1'b0;
		for (int i = 0; i < NSLOT; i++) begin
			sh_bound[i] = 0;
			sh_conn[i] = 0;
			sh_local_ip[i] = '0;
			sh_local_port[i] = '0;
			sh_peer_ip[i] = '0;
			sh_peer_port[i] = '0;
		end
		sh_eph_low = EPH_LOW_RESET;
		sh_eph_high = EPH_HIGH_RESET;
		sh_cursor = EPH_LOW_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		run_random(450);
		test_exhaustion();
		write_reg(REG_EPH_HIGH, 16'd140);
		run_random(350);
		test_port_zero();
		write_reg(REG_EPH_LOW, 16'd65500);
		write_reg(REG_EPH_HIGH, 16'd65535);
		run_random(200);
		test_empty_range();
		write_reg(REG_EPH_LOW, 16'd1);
		write_reg(REG_EPH_HIGH, 16'd65535);
		no_idle = 1;
		run_random(250);

		req.valid <= 1'b0;
		wait (answers_due.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("udp_port_bind_and_demux_table_core: match");
		else
			$display("udp_port_bind_and_demux_table_core: mismatch");
		$finish;
	end

endmodule
